// ===== rtl/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Shared widths, request and status codes, and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int unsigned NUM_FRAMES_DEF = 4096;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned BIT_IDX_W      = 5;
  localparam int unsigned MAX_WORDS      = 128;
  localparam int unsigned FRAME_W        = 12;
  localparam int unsigned REQ_W          = 2;
  localparam int unsigned CFG_W          = 13;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned LIM_W          = 8;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 13'd4096;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEST  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_CHANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FRAMES = 2'd2;

  typedef enum logic [2:0] {
    RES_HELD,
    RES_ALLOC,
    RES_NO_FRAMES,
    RES_DONE,
    RES_NO_CHANGE,
    RES_TEST
  } res_e;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_CUR,
    RD_TST
  } rd_src_e;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [FRAME_W-1:0] current_frame;
    logic [FRAME_W-1:0] frame_index;
    logic               supervisor;
    logic               writable;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_out;
    logic                present_bit;
    logic                rw_bit;
    logic                user_bit;
    logic                in_use;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic    load_req;
    logic    scan_clr;
    logic    rd_issue;
    rd_src_e rd_src;
    logic    wr_set;
    logic    wr_clr;
    logic    res_load;
    res_e    res_kind;
    logic    push_out;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             cur_nz;
    logic             cur_ok;
    logic             tst_ok;
    logic             scan_done;
    logic             rd_valid;
    logic             rd_hit;
    logic             out_free;
  } sts_t;

endpackage

// ===== rtl/fba_if.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fba_req_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::REQ_W-1:0]     req_type;
  logic [fba_pkg::FRAME_W-1:0]   current_frame;
  logic [fba_pkg::FRAME_W-1:0]   frame_index;
  logic                          supervisor;
  logic                          writable;

  modport source (
    output valid, req_type, current_frame, frame_index, supervisor, writable,
    input  ready
  );
  modport sink (
    input  valid, req_type, current_frame, frame_index, supervisor, writable,
    output ready
  );
endinterface

interface fba_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [fba_pkg::FRAME_W-1:0]    frame_out;
  logic                           present_bit;
  logic                           rw_bit;
  logic                           user_bit;
  logic                           in_use;
  logic [fba_pkg::STATUS_W-1:0]   status;

  modport source (
    output valid, frame_out, present_bit, rw_bit, user_bit, in_use, status,
    input  ready
  );
  modport sink (
    input  valid, frame_out, present_bit, rw_bit, user_bit, in_use, status,
    output ready
  );
endinterface

interface fba_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fba_pkg::CFG_W-1:0]   frame_count;

  modport source (
    output valid, frame_count,
    input  ready
  );
  modport sink (
    input  valid, frame_count,
    output ready
  );
endinterface

// ===== rtl/fba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator controller
// Sequences one request at a time: decode, a bitmap scan, read-modify-write
// or test read if needed, then hand the result to the response register.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fba_pkg::sts_t sts_i,
  output fba_pkg::cmd_t cmd_o
);
  import fba_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FREE_RMW,
    ST_TEST_RD,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o      = cmd;

  always_comb begin
    cmd        = '0;
    cmd.rd_src = RD_SCAN;
    state_d    = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_req = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.req_type)
          REQ_ALLOC: begin
            if (sts_i.cur_nz) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_HELD;
              state_d      = ST_FINISH;
            end else begin
              cmd.scan_clr = 1'b1;
              state_d      = ST_SCAN;
            end
          end
          REQ_FREE: begin
            if (sts_i.cur_nz && sts_i.cur_ok) begin
              cmd.rd_issue = 1'b1;
              cmd.rd_src   = RD_CUR;
              state_d      = ST_FREE_RMW;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_kind = sts_i.cur_nz ? RES_DONE : RES_NO_CHANGE;
              state_d      = ST_FINISH;
            end
          end
          REQ_TEST: begin
            if (sts_i.tst_ok) begin
              cmd.rd_issue = 1'b1;
              cmd.rd_src   = RD_TST;
              state_d      = ST_TEST_RD;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_DONE;
              state_d      = ST_FINISH;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_NO_CHANGE;
            state_d      = ST_FINISH;
          end
        endcase
      end
      ST_SCAN: begin
        // One word read is in flight at a time; the scan ends on the first
        // word with a clear bit or once every word up to the scan limit has come back full.
        if (sts_i.rd_hit) begin
          cmd.wr_set   = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_ALLOC;
          state_d      = ST_FINISH;
        end else if (!sts_i.rd_valid && sts_i.scan_done) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_NO_FRAMES;
          state_d      = ST_FINISH;
        end else if (!sts_i.scan_done) begin
          cmd.rd_issue = 1'b1;
          cmd.rd_src   = RD_SCAN;
        end
      end
      ST_FREE_RMW: begin
        cmd.wr_clr   = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_DONE;
        state_d      = ST_FINISH;
      end
      ST_TEST_RD: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_TEST;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd.push_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/fba_datapath.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator datapath
// Bitmap memory with per-word valid flags, scan counter, lowest-clear-bit
// encoder, result and response registers, and the frame count register.
// ----------------------------------------------------------------------------
module fba_datapath #(
  parameter int unsigned NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fba_pkg::cmd_t             cmd_i,
  output fba_pkg::sts_t             sts_o,
  input  fba_pkg::req_t             req_i,
  input  logic                      cfg_valid_i,
  input  logic [fba_pkg::CFG_W-1:0] cfg_data_i,
  output fba_pkg::rsp_t             rsp_o,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i
);
  import fba_pkg::*;

  localparam int unsigned BM_WORDS  = NUM_FRAMES / WORD_W;
  localparam int unsigned MEM_WORDS = (BM_WORDS < MAX_WORDS) ? BM_WORDS : MAX_WORDS;
  localparam int unsigned WA_W      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [LIM_W-1:0]  MEM_WORDS_L = LIM_W'(MEM_WORDS);
  localparam logic [WORD_W-1:0] ALL_ONES    = '1;
  localparam int unsigned FWORD_W   = FRAME_W - BIT_IDX_W;

  req_t               req_q;
  logic [CFG_W-1:0]   frame_count_q;
  logic [LIM_W-1:0]   scan_w_q;
  logic               rd_valid_q;
  logic [WA_W-1:0]    rd_addr_q;
  logic [WA_W-1:0]    rd_addr_d;
  logic [WORD_W-1:0]  rd_data_q;
  logic               rd_vld_q;
  logic [WORD_W-1:0]  mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_q;
  rsp_t               res_q, res_d;
  rsp_t               rsp_q;
  logic               rsp_valid_q;

  logic [FWORD_W-1:0]   cur_word, tst_word;
  logic [LIM_W-1:0]     scan_lim;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    low_clear;
  logic [BIT_IDX_W-1:0] found_idx;
  logic [FRAME_W-1:0]   found_frame;
  logic [WORD_W-1:0]    free_mask;
  logic [WORD_W-1:0]    wr_data;
  logic                 wr_en;

  assign cur_word = req_q.current_frame[FRAME_W-1:BIT_IDX_W];
  assign tst_word = req_q.frame_index[FRAME_W-1:BIT_IDX_W];

  // Only whole 32-frame words are scanned, and never past the bitmap.
  assign scan_lim = (frame_count_q[CFG_W-1:BIT_IDX_W] < MEM_WORDS_L) ?
                    frame_count_q[CFG_W-1:BIT_IDX_W] : MEM_WORDS_L;

  always_comb begin
    case (cmd_i.rd_src)
      RD_SCAN: rd_addr_d = scan_w_q[WA_W-1:0];
      RD_CUR:  rd_addr_d = WA_W'(cur_word);
      RD_TST:  rd_addr_d = WA_W'(tst_word);
      default: rd_addr_d = scan_w_q[WA_W-1:0];
    endcase
  end

  // A word that was never written reads as all zeros through its valid flag.
  assign word      = rd_vld_q ? rd_data_q : '0;
  assign low_clear = ~word & (word + WORD_W'(1));

  always_comb begin
    found_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low_clear[i]) begin
        found_idx = found_idx | BIT_IDX_W'(i);
      end
    end
  end

  assign found_frame = (FRAME_W'(rd_addr_q) << BIT_IDX_W) | FRAME_W'(found_idx);
  assign free_mask   = WORD_W'(1) << req_q.current_frame[BIT_IDX_W-1:0];
  assign wr_en       = cmd_i.wr_set | cmd_i.wr_clr;
  assign wr_data     = cmd_i.wr_set ? (word | low_clear) : (word & ~free_mask);

  always_comb begin
    res_d = '0;
    case (cmd_i.res_kind)
      RES_HELD: begin
        res_d.frame_out   = req_q.current_frame;
        res_d.present_bit = 1'b1;
        res_d.status      = STATUS_NO_CHANGE;
      end
      RES_ALLOC: begin
        res_d.frame_out   = found_frame;
        res_d.present_bit = 1'b1;
        res_d.rw_bit      = req_q.writable;
        res_d.user_bit    = ~req_q.supervisor;
        res_d.status      = STATUS_DONE;
      end
      RES_NO_FRAMES: res_d.status = STATUS_NO_FRAMES;
      RES_DONE:      res_d.status = STATUS_DONE;
      RES_NO_CHANGE: res_d.status = STATUS_NO_CHANGE;
      RES_TEST: begin
        res_d.in_use = word[req_q.frame_index[BIT_IDX_W-1:0]];
        res_d.status = STATUS_DONE;
      end
      default: res_d.status = STATUS_NO_CHANGE;
    endcase
  end

  always_comb begin
    sts_o           = '0;
    sts_o.req_type  = req_q.req_type;
    sts_o.cur_nz    = (req_q.current_frame != '0);
    sts_o.cur_ok    = (32'(cur_word) < MEM_WORDS);
    sts_o.tst_ok    = (32'(tst_word) < MEM_WORDS);
    sts_o.scan_done = (scan_w_q >= scan_lim);
    sts_o.rd_valid  = rd_valid_q;
    sts_o.rd_hit    = rd_valid_q && (word != ALL_ONES);
    sts_o.out_free  = !rsp_valid_q || rsp_ready_i;
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // Bitmap memory: one read and one write port, read data registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[rd_addr_d];
      rd_vld_q  <= vld_q[rd_addr_d];
      rd_addr_q <= rd_addr_d;
    end
    if (wr_en) begin
      mem[rd_addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.push_out) begin
      rsp_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q         <= '0;
      frame_count_q <= FRAME_COUNT_RST;
      scan_w_q      <= '0;
      rd_valid_q    <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[rd_addr_q] <= 1'b1;
      end
      if (cfg_valid_i) begin
        frame_count_q <= cfg_data_i;
      end
      if (cmd_i.scan_clr) begin
        scan_w_q <= '0;
      end else if (cmd_i.rd_issue && (cmd_i.rd_src == RD_SCAN)) begin
        scan_w_q <= scan_w_q + LIM_W'(1);
      end
      rd_valid_q <= cmd_i.rd_issue;
      if (cmd_i.push_out) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/frame_bitmap_allocator.sv =====
// Answered from decode without a bitmap read: allocate on a held frame, free of frame 0
// or of a frame past the bitmap, out-of-range test and unused codes. Free and test read
// one word; allocate scans from word 0 until a word with a clear bit or the scan limit.
// Throughput: one request at a time; the scan reads one bitmap word per cycle from the
// single read port, and a new request is taken while the previous response waits.
// Reset: every frame reads as free through per-word valid flags, frame_count is 4096.
// ----------------------------------------------------------------------------
// Frame bitmap allocator
// First-fit page frame allocator over a bitmap of 32-frame words, with
// allocate, free and test requests and a frame count register.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
  parameter int unsigned NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  fba_req_if.sink   req_i,
  fba_rsp_if.source rsp_o,
  fba_cfg_if.sink   cfg_i
);
  import fba_pkg::*;

  cmd_t cmd;
  sts_t sts;
  req_t req_bus;
  rsp_t rsp_bus;
  logic rsp_valid;

  assign req_bus.req_type      = req_i.req_type;
  assign req_bus.current_frame = req_i.current_frame;
  assign req_bus.frame_index   = req_i.frame_index;
  assign req_bus.supervisor    = req_i.supervisor;
  assign req_bus.writable      = req_i.writable;

  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid       = rsp_valid;
  assign rsp_o.frame_out   = rsp_bus.frame_out;
  assign rsp_o.present_bit = rsp_bus.present_bit;
  assign rsp_o.rw_bit      = rsp_bus.rw_bit;
  assign rsp_o.user_bit    = rsp_bus.user_bit;
  assign rsp_o.in_use      = rsp_bus.in_use;
  assign rsp_o.status      = rsp_bus.status;

  fba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fba_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_bus),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.frame_count),
    .rsp_o       (rsp_bus),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready)
  );

endmodule

// ===== rtl/fba_checker.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator port checker
// Watches the top-level channels and checks handshake and response rules.
// ----------------------------------------------------------------------------
module fba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [fba_pkg::FRAME_W-1:0]   frame_out_i,
  input logic                          present_bit_i,
  input logic                          rw_bit_i,
  input logic                          user_bit_i,
  input logic                          in_use_i,
  input logic [fba_pkg::STATUS_W-1:0]  status_i
);
  import fba_pkg::*;

  // A stalled response keeps its valid, frame, status and present bit.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(frame_out_i) &&
    $stable(status_i) && $stable(present_bit_i))
    else $error("response changed while stalled");

  // The block works on one request at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted in back-to-back cycles");

  a_no_frames_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STATUS_NO_FRAMES) |->
    (frame_out_i == '0) && !present_bit_i && !rw_bit_i && !user_bit_i && !in_use_i)
    else $error("out-of-frames response carries data");

  a_in_use_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && in_use_i |-> (status_i == STATUS_DONE) && !present_bit_i &&
    (frame_out_i == '0))
    else $error("in-use flag on a response that is not a test");

  a_flags_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rw_bit_i || user_bit_i) |-> present_bit_i && (status_i == STATUS_DONE))
    else $error("access flags outside a completed allocation");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .frame_out_i   (rsp_o.frame_out),
  .present_bit_i (rsp_o.present_bit),
  .rw_bit_i      (rsp_o.rw_bit),
  .user_bit_i    (rsp_o.user_bit),
  .in_use_i      (rsp_o.in_use),
  .status_i      (rsp_o.status)
);

// ===== tb/sv/fba_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator checker
// Watches the request, response and configuration channels, keeps its own
// copy of the frame bitmap and frame count, works out the response of every
// accepted request and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module fba_frame_checker #(
  parameter int unsigned NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fba_req_if          req_i,
  fba_rsp_if          rsp_i,
  fba_cfg_if          cfg_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import fba_pkg::*;

  localparam int unsigned MAP_WORDS = NUM_FRAMES / WORD_W;

  logic [WORD_W-1:0] frame_map [MAP_WORDS];
  logic [CFG_W-1:0]  frame_count;
  rsp_t              frame_results_due [$];
  rsp_t              want;
  rsp_t              got;
  req_t              taken;

  function automatic logic frame_in_map(input logic [FRAME_W-1:0] frame);
    return (frame / WORD_W) < MAP_WORDS;
  endfunction

  // First fit over whole words only; a partial last word is never scanned.
  function automatic logic find_first_free(output logic [FRAME_W-1:0] frame);
    int unsigned words;
    words = frame_count / WORD_W;
    if (words > MAP_WORDS) words = MAP_WORDS;
    if (words > MAX_WORDS) words = MAX_WORDS;
    frame = '0;
    for (int unsigned w = 0; w < words; w++) begin
      for (int unsigned b = 0; b < WORD_W; b++) begin
        if (!frame_map[w][b]) begin
          frame = FRAME_W'(w * WORD_W + b);
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t apply_request(input req_t r);
    rsp_t               res;
    logic [FRAME_W-1:0] frame;
    res = '0;
    case (r.req_type)
      REQ_ALLOC: begin
        if (r.current_frame != '0) begin
          res.frame_out   = r.current_frame;
          res.present_bit = 1'b1;
          res.status      = STATUS_NO_CHANGE;
        end else if (find_first_free(frame)) begin
          frame_map[frame / WORD_W][frame % WORD_W] = 1'b1;
          res.frame_out   = frame;
          res.present_bit = 1'b1;
          res.rw_bit      = r.writable;
          res.user_bit    = ~r.supervisor;
          res.status      = STATUS_DONE;
        end else begin
          res.status = STATUS_NO_FRAMES;
        end
      end
      REQ_FREE: begin
        if (r.current_frame != '0) begin
          if (frame_in_map(r.current_frame)) begin
            frame_map[r.current_frame / WORD_W][r.current_frame % WORD_W] = 1'b0;
          end
          res.status = STATUS_DONE;
        end else begin
          res.status = STATUS_NO_CHANGE;
        end
      end
      REQ_TEST: begin
        if (frame_in_map(r.frame_index)) begin
          res.in_use = frame_map[r.frame_index / WORD_W][r.frame_index % WORD_W];
        end
        res.status = STATUS_DONE;
      end
      default: begin
        res.status = STATUS_NO_CHANGE;
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (frame_map[w]) frame_map[w] = '0;
      frame_count = FRAME_COUNT_RST;
      frame_results_due.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // The response leaving at this edge always belongs to an older request.
      if (rsp_i.valid && rsp_i.ready) begin
        got.frame_out   = rsp_i.frame_out;
        got.present_bit = rsp_i.present_bit;
        got.rw_bit      = rsp_i.rw_bit;
        got.user_bit    = rsp_i.user_bit;
        got.in_use      = rsp_i.in_use;
        got.status      = rsp_i.status;
        if (frame_results_due.size() == 0) begin
          $display("%0t: response with no request outstanding, expected none, actual %h",
                   $time, got);
          errors_o++;
        end else begin
          want = frame_results_due.pop_front();
          compare_field("frame_out", want.frame_out, got.frame_out);
          compare_field("present_bit", want.present_bit, got.present_bit);
          compare_field("rw_bit", want.rw_bit, got.rw_bit);
          compare_field("user_bit", want.user_bit, got.user_bit);
          compare_field("in_use", want.in_use, got.in_use);
          compare_field("status", want.status, got.status);
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        frame_count = cfg_i.frame_count;
      end
      if (req_i.valid && req_i.ready) begin
        taken.req_type      = req_i.req_type;
        taken.current_frame = req_i.current_frame;
        taken.frame_index   = req_i.frame_index;
        taken.supervisor    = req_i.supervisor;
        taken.writable      = req_i.writable;
        frame_results_due.push_back(apply_request(taken));
      end
      pending_o = frame_results_due.size();
    end
  end

endmodule

// ===== tb/sv/frame_bitmap_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator testbench
// Drives directed and random allocate, free, test and unused-code requests through
// several frame count settings, with random gaps and stalls on both sides,
// and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_tb;
  import fba_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
  localparam int unsigned      HOLD_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  int unsigned errors;
  int unsigned pending;
  logic        quiet;
  logic        hold_rsp;
  logic        rsp_calm;
  logic        gaps_on;
  int unsigned allocs_sent;
  int unsigned fc_now;

  fba_req_if req_if ();
  fba_rsp_if rsp_if ();
  fba_cfg_if cfg_if ();

  frame_bitmap_allocator DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  fba_frame_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .cfg_i     (cfg_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Stall mode for the response side is redrawn repeatedly; one draw in three is calm.
  initial begin
    rsp_calm = 1'b0;
    forever begin
      repeat (48) @(posedge clk);
      rsp_calm = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (!quiet && !rsp_calm && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [FRAME_W-1:0] cur,
                              input logic [FRAME_W-1:0] idx, input logic kern,
                              input logic wr);
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.current_frame <= cur;
    req_if.frame_index   <= idx;
    req_if.supervisor    <= kern;
    req_if.writable      <= wr;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] count);
    wait_idle();
    cfg_if.valid       <= 1'b1;
    cfg_if.frame_count <= count;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    fc_now = count;
  endtask

  // Frees and tests mostly aim at the low frames that first fit hands out.
  task automatic random_request(input int unsigned alloc_weight);
    int unsigned        pick;
    int unsigned        span;
    logic [FRAME_W-1:0] near;
    logic [FRAME_W-1:0] anyf;
    logic               kern;
    logic               wr;
    span = ((allocs_sent < fc_now) ? allocs_sent : fc_now) + 16;
    if (span > 4095) span = 4095;
    near = FRAME_W'($urandom_range(0, span));
    anyf = FRAME_W'($urandom);
    kern = 1'($urandom_range(0, 1));
    wr   = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < alloc_weight) begin
      send_request(REQ_ALLOC, '0, anyf, kern, wr);
      allocs_sent++;
    end else if (pick < alloc_weight + 8) begin
      send_request(REQ_ALLOC, anyf, near, kern, wr);
    end else if (pick < alloc_weight + 30) begin
      send_request(REQ_FREE, ($urandom_range(0, 9) == 0) ? anyf : near, anyf, kern, wr);
    end else if (pick < alloc_weight + 47) begin
      send_request(REQ_TEST, anyf, ($urandom_range(0, 4) == 0) ? anyf : near, kern, wr);
    end else if (pick < alloc_weight + 50) begin
      send_request(REQ_UNUSED, anyf, near, kern, wr);
    end else begin
      send_request(REQ_TEST, anyf, near, kern, wr);
    end
  endtask

  task automatic run_phase(input int unsigned items, input int unsigned alloc_weight);
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 16 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      random_request(alloc_weight);
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_ALLOC;
    req_if.current_frame = '0;
    req_if.frame_index   = '0;
    req_if.supervisor    = 1'b0;
    req_if.writable      = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.frame_count   = FRAME_COUNT_RST;
    quiet                = 1'b0;
    hold_rsp             = 1'b0;
    gaps_on              = 1'b1;
    allocs_sent          = 0;
    fc_now               = FRAME_COUNT_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset frame count.
    send_request(REQ_TEST, 12'hfff, 12'd0, 1'b0, 1'b0);
    send_request(REQ_ALLOC, 12'd0, 12'hfff, 1'b0, 1'b1);
    send_request(REQ_ALLOC, 12'd0, 12'd0, 1'b1, 1'b0);
    send_request(REQ_TEST, 12'd0, 12'd0, 1'b1, 1'b1);
    send_request(REQ_TEST, 12'd0, 12'hfff, 1'b0, 1'b0);
    send_request(REQ_ALLOC, 12'hfff, 12'd0, 1'b1, 1'b1);
    send_request(REQ_ALLOC, 12'd1, 12'd0, 1'b0, 1'b0);
    send_request(REQ_FREE, 12'd0, 12'hfff, 1'b1, 1'b1);
    send_request(REQ_FREE, 12'd1, 12'd0, 1'b0, 1'b0);
    send_request(REQ_TEST, 12'd0, 12'd1, 1'b0, 1'b0);
    send_request(REQ_FREE, 12'hfff, 12'd0, 1'b0, 1'b0);
    send_request(REQ_UNUSED, 12'hfff, 12'hfff, 1'b1, 1'b1);
    send_request(REQ_ALLOC, 12'd0, 12'h555, 1'b1, 1'b1);
    send_request(REQ_TEST, 12'h555, 12'h800, 1'b0, 1'b1);
    send_request(REQ_FREE, 12'haaa, 12'h555, 1'b1, 1'b0);
    send_request(REQ_TEST, 12'h555, 12'haaa, 1'b1, 1'b0);
    allocs_sent = 3;

    // A single scanned word fills quickly and runs out of frames.
    write_frame_count(13'd32);
    run_phase(80, 70);

    // The block fills up while the response side holds off.
    write_frame_count(13'd4096);
    run_phase(30, 45);
    hold_rsp = 1'b1;
    run_phase(70, 45);

    write_frame_count(13'd63);
    run_phase(60, 60);

    write_frame_count(13'd100);
    run_phase(40, 50);
    wait_idle();
    run_phase(40, 50);

    write_frame_count(13'd1000);
    run_phase(100, 45);

    write_frame_count(13'd4095);
    run_phase(100, 40);

    write_frame_count(13'd32);
    run_phase(60, 55);

    write_frame_count(13'd4096);
    @(posedge clk);
    quiet = 1'b1;
    run_phase(100, 45);

    wait_idle();
    repeat (16) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
